// ----- src/interval_set_build_and_lookup_assert.svh -----
// Assertion macros shared by the checker of the interval set block.
// Depends on nothing; included by the checker file.
`ifndef INTERVAL_SET_BUILD_AND_LOOKUP_ASSERT_SVH
`define INTERVAL_SET_BUILD_AND_LOOKUP_ASSERT_SVH
// Implication checked at every clock edge outside reset.
`define ISB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define ISB_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ----- src/isb_pkg.sv -----
// Package of the interval set block: opcodes, status codes and command types.
// Depends on nothing; used by all modules of the block.
package isb_pkg;
    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_BUILD = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // Datapath commands issued by the controller.
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LATCH,      // register the input item
        CMD_ADD,        // append the latched range to staging
        CMD_SORT_INIT,  // start insertion sort, i = 1
        CMD_SORT_KEY,   // issue read of staged[i]
        CMD_SORT_CMP,   // issue read of staged[j-1]
        CMD_SORT_STEP,  // compare, shift or place key
        CMD_MERGE_INIT, // issue read of staged[0]
        CMD_MERGE_RD,   // issue read of staged[i]
        CMD_MERGE_STEP, // merge or emit
        CMD_MERGE_END,  // emit last range, clear staging
        CMD_BUILD_NONE, // empty build
        CMD_Q_INIT,     // start binary search
        CMD_Q_RD,       // issue read of set[m]
        CMD_Q_STEP      // compare and narrow
    } cmd_t;

    typedef struct packed {
        logic op_add;
        logic op_build;
        logic op_query;
        logic staged_zero;
        logic sort_more;    // i < n
        logic sort_shift;   // j > 0 and staged[j-1].lo > key.lo
        logic sort_j_pos;   // j > 0
        logic merge_more;   // i < n
        logic q_more;       // l <= r and not found
    } stat_t;
endpackage

// ----- src/isb_datapath.sv -----
// Datapath of the interval set block: staging and set memories, sort, merge,
// total and binary search registers. Depends on isb_pkg.
module isb_datapath #(
    parameter int MAX_RANGES = 64,
    parameter int IW = 7
) (
    input  logic                clk,
    input  logic                rst_n,
    input  isb_pkg::cmd_t       cmd,
    output isb_pkg::stat_t      stat,
    input  logic [1:0]          opcode,
    input  logic signed [31:0]  range_low,
    input  logic signed [31:0]  range_high,
    input  logic signed [31:0]  query_value,
    output logic                member_q,
    output logic [1:0]          status_q,
    output logic [IW-1:0]       set_count,
    output logic [31:0]         set_total
);
    import isb_pkg::*;
    localparam int AW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam logic [IW-1:0] CAP = IW'(MAX_RANGES);
    localparam logic signed [IW:0] ONE_S = (IW+1)'(1);

    logic [63:0] stg_mem [MAX_RANGES];
    logic [63:0] set_mem [MAX_RANGES];
    logic [63:0] stg_rd_reg;
    logic [63:0] set_rd_reg;

    logic [1:0]         op_reg;
    logic signed [31:0] lo_in_reg, hi_in_reg, qv_reg;
    logic [IW-1:0]      stg_cnt_reg, set_cnt_reg;
    logic [31:0]        total_reg;
    logic [IW-1:0]      i_reg, j_reg, k_reg;
    logic [63:0]        key_reg;
    logic signed [31:0] mlo_reg, mhi_reg;
    logic signed [IW:0] l_reg, r_reg, m_reg;
    logic               found_reg, member_reg;
    logic [1:0]         status_reg;

    logic stg_we;
    logic [AW-1:0] stg_wa, stg_ra;
    logic [63:0] stg_wd;
    logic set_we;
    logic [AW-1:0] set_wa, set_ra;
    logic [63:0] set_wd;

    logic signed [31:0] rd_lo, rd_hi, key_lo, s_lo, s_hi;
    logic signed [32:0] hi_p1;
    logic signed [32:0] rd_lo_x;
    logic [31:0]        width_w;
    logic signed [IW:0] m_next;

    assign rd_lo = stg_rd_reg[63:32];
    assign rd_hi = stg_rd_reg[31:0];
    assign key_lo = key_reg[63:32];
    assign s_lo = set_rd_reg[63:32];
    assign s_hi = set_rd_reg[31:0];
    assign hi_p1 = {mhi_reg[31], mhi_reg} + 33'sd1;
    // Sign-extended lower bound, so the touching test is a signed compare.
    assign rd_lo_x = $signed({rd_lo[31], rd_lo});
    assign width_w = 32'(mhi_reg - mlo_reg) + 32'd1;
    assign m_next = l_reg + ((r_reg - l_reg) >>> 1);

    always_comb
    begin
        stg_we = 1'b0;
        stg_wa = stg_cnt_reg[AW-1:0];
        stg_wd = {lo_in_reg, hi_in_reg};
        stg_ra = '0;
        set_we = 1'b0;
        set_wa = k_reg[AW-1:0];
        set_wd = {mlo_reg, mhi_reg};
        set_ra = m_next[AW-1:0];
        case (cmd)
            CMD_ADD: stg_we = (lo_in_reg <= hi_in_reg) && (stg_cnt_reg < CAP);
            CMD_SORT_KEY: stg_ra = i_reg[AW-1:0];
            CMD_SORT_CMP: stg_ra = AW'(j_reg - 1'b1);
            CMD_SORT_STEP:
            begin
                stg_we = 1'b1;
                if (j_reg != '0 && rd_lo > key_lo)
                begin
                    stg_wa = j_reg[AW-1:0];
                    stg_wd = stg_rd_reg;
                end
                else
                begin
                    stg_wa = j_reg[AW-1:0];
                    stg_wd = key_reg;
                end
            end
            CMD_MERGE_RD: stg_ra = i_reg[AW-1:0];
            CMD_MERGE_STEP: set_we = (i_reg != '0) && (hi_p1 < rd_lo_x);
            CMD_MERGE_END: set_we = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (stg_we)
            stg_mem[stg_wa] <= stg_wd;
        stg_rd_reg <= stg_mem[stg_ra];
        if (set_we)
            set_mem[set_wa] <= set_wd;
        set_rd_reg <= set_mem[set_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_cnt_reg <= '0;
            set_cnt_reg <= '0;
            total_reg   <= '0;
            op_reg      <= '0;
            lo_in_reg   <= '0;
            hi_in_reg   <= '0;
            qv_reg      <= '0;
            mlo_reg     <= '0;
            mhi_reg     <= '0;
            i_reg <= '0; j_reg <= '0; k_reg <= '0;
            l_reg <= '0; r_reg <= '0; m_reg <= '0;
            found_reg <= 1'b0;
            member_reg <= 1'b0;
            status_reg <= ST_DONE;
        end
        else
        begin
            case (cmd)
                CMD_LATCH:
                begin
                    op_reg <= opcode;
                    lo_in_reg <= range_low;
                    hi_in_reg <= range_high;
                    qv_reg <= query_value;
                    member_reg <= 1'b0;
                    status_reg <= ST_DONE;
                end
                CMD_ADD:
                begin
                    if (lo_in_reg > hi_in_reg)
                        status_reg <= ST_EMPTY;
                    else if (stg_cnt_reg >= CAP)
                        status_reg <= ST_FULL;
                    else
                        stg_cnt_reg <= stg_cnt_reg + 1'b1;
                end
                CMD_SORT_INIT: i_reg <= IW'(1);
                CMD_SORT_KEY: j_reg <= i_reg;
                CMD_SORT_CMP:
                begin
                    if (stat.sort_j_pos == 1'b0)
                        ;
                end
                CMD_SORT_STEP:
                begin
                    if (j_reg != '0 && rd_lo > key_lo)
                        j_reg <= j_reg - 1'b1;
                    else
                        i_reg <= i_reg + 1'b1;
                end
                CMD_MERGE_INIT:
                begin
                    i_reg <= '0;
                    k_reg <= '0;
                    total_reg <= '0;
                end
                CMD_MERGE_RD: ;
                CMD_MERGE_STEP:
                begin
                    if (i_reg == '0)
                    begin
                        mlo_reg <= rd_lo;
                        mhi_reg <= rd_hi;
                    end
                    else if (hi_p1 < rd_lo_x)
                    begin
                        total_reg <= total_reg + width_w;
                        k_reg <= k_reg + 1'b1;
                        mlo_reg <= rd_lo;
                        mhi_reg <= rd_hi;
                    end
                    else if (rd_hi > mhi_reg)
                        mhi_reg <= rd_hi;
                    i_reg <= i_reg + 1'b1;
                end
                CMD_MERGE_END:
                begin
                    total_reg <= total_reg + width_w;
                    set_cnt_reg <= k_reg + 1'b1;
                    stg_cnt_reg <= '0;
                end
                CMD_BUILD_NONE:
                begin
                    set_cnt_reg <= '0;
                    total_reg <= '0;
                end
                CMD_Q_INIT:
                begin
                    l_reg <= '0;
                    r_reg <= $signed({1'b0, set_cnt_reg}) - ONE_S;
                    found_reg <= 1'b0;
                end
                CMD_Q_RD: m_reg <= m_next;
                CMD_Q_STEP:
                begin
                    if (s_lo <= qv_reg && qv_reg <= s_hi)
                    begin
                        found_reg <= 1'b1;
                        member_reg <= 1'b1;
                    end
                    else if (qv_reg < s_lo)
                        r_reg <= m_reg - ONE_S;
                    else
                        l_reg <= m_reg + ONE_S;
                end
                default: ;
            endcase
        end
    end

    // key register captures staged[i] the cycle after its read issue
    always_ff @(posedge clk)
    begin
        if (cmd == CMD_SORT_CMP && j_reg == i_reg)
            key_reg <= stg_rd_reg;
    end

    always_comb
    begin
        stat.op_add      = (op_reg == OP_ADD);
        stat.op_build    = (op_reg == OP_BUILD);
        stat.op_query    = (op_reg == OP_QUERY);
        stat.staged_zero = (stg_cnt_reg == '0);
        stat.sort_more   = (i_reg < stg_cnt_reg);
        stat.sort_j_pos  = (j_reg != '0);
        stat.sort_shift  = (j_reg != '0) && (rd_lo > key_lo);
        stat.merge_more  = (i_reg < stg_cnt_reg);
        stat.q_more      = !found_reg && (l_reg <= r_reg);
    end

    assign member_q  = member_reg;
    assign status_q  = status_reg;
    assign set_count = set_cnt_reg;
    assign set_total = total_reg;
endmodule

// ----- src/isb_control.sv -----
// Controller of the interval set block: sequences add, build and query.
// Depends on isb_pkg.
module isb_control (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  isb_pkg::stat_t stat,
    output isb_pkg::cmd_t  cmd
);
    import isb_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DISP, S_ADD, S_SINIT, S_SKEY, S_SKEYW, S_SSTEP,
        S_MINIT, S_MRD, S_MSTEP, S_MEND, S_QRD, S_QSTEP, S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        out_valid_next = out_valid_reg;
        cmd = CMD_NONE;
        unique case (state_reg)
            S_IDLE:
                if (in_valid)
                begin
                    cmd = CMD_LATCH;
                    state_next = S_DISP;
                end
            S_DISP:
                if (stat.op_add)
                    state_next = S_ADD;
                else if (stat.op_build)
                begin
                    if (stat.staged_zero)
                    begin
                        cmd = CMD_BUILD_NONE;
                        state_next = S_OUT;
                        out_valid_next = 1'b1;
                    end
                    else
                    begin
                        cmd = CMD_SORT_INIT;
                        state_next = S_SKEY;
                    end
                end
                else if (stat.op_query)
                begin
                    cmd = CMD_Q_INIT;
                    state_next = S_QRD;
                end
                else
                begin
                    state_next = S_OUT;
                    out_valid_next = 1'b1;
                end
            S_ADD:
            begin
                cmd = CMD_ADD;
                state_next = S_OUT;
                out_valid_next = 1'b1;
            end
            S_SINIT: state_next = S_SKEY;
            S_SKEY:
                if (stat.sort_more)
                begin
                    cmd = CMD_SORT_KEY;
                    state_next = S_SKEYW;
                end
                else
                    state_next = S_MINIT;
            // Capture the key when j == i, and read staged[j-1]; the read data
            // is in the read register for the step that follows.
            S_SKEYW:
            begin
                cmd = CMD_SORT_CMP;
                state_next = S_SSTEP;
            end
            S_SSTEP:
            begin
                cmd = CMD_SORT_STEP;
                if (stat.sort_shift)
                    state_next = S_SKEYW;
                else
                    state_next = S_SKEY;
            end
            S_MINIT:
            begin
                cmd = CMD_MERGE_INIT;
                state_next = S_MRD;
            end
            S_MRD:
                if (stat.merge_more)
                begin
                    cmd = CMD_MERGE_RD;
                    state_next = S_MSTEP;
                end
                else
                    state_next = S_MEND;
            S_MSTEP:
            begin
                cmd = CMD_MERGE_STEP;
                state_next = S_MRD;
            end
            S_MEND:
            begin
                cmd = CMD_MERGE_END;
                state_next = S_OUT;
                out_valid_next = 1'b1;
            end
            S_QRD:
                if (stat.q_more)
                begin
                    cmd = CMD_Q_RD;
                    state_next = S_QSTEP;
                end
                else
                begin
                    state_next = S_OUT;
                    out_valid_next = 1'b1;
                end
            S_QSTEP:
            begin
                cmd = CMD_Q_STEP;
                state_next = S_QRD;
            end
            S_OUT:
                if (out_ready)
                begin
                    state_next = S_IDLE;
                    out_valid_next = 1'b0;
                end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
endmodule

// ----- src/interval_set_build_and_lookup.sv -----
// Top level of the interval set block: controller plus datapath.
// Depends on isb_pkg, isb_control and isb_datapath.
//
// Usage. Items arrive on a valid/ready input channel (opcode, range_low,
// range_high, query_value); each produces exactly one result transfer on a
// valid/ready output channel (is_member, status, range_count, member_total).
// An add appends a range to the staging memory, or reports an empty or a
// dropped range in status. A build sorts the staged ranges by lower bound
// with an insertion sort over the staging memory, merges overlapping or
// touching ranges into the set memory, sums their sizes and empties staging.
// A query runs a binary search over the set memory.
// One item is processed at a time. A query whose search makes s probes
// (s at most ceil(log2(count+1))) issues one read and one compare step per
// probe, and each memory has a single read port. The input is ready again
// the cycle after the result transfer.
// Reset clears the counts and total; memory contents are not cleared, as
// entries beyond the counts are never used. While the receiver stalls the
// result is held on the output ports and no new item is taken.
module interval_set_build_and_lookup #(
    parameter int MAX_RANGES = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         opcode,
    input  logic signed [31:0] range_low,
    input  logic signed [31:0] range_high,
    input  logic signed [31:0] query_value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               is_member,
    output logic [1:0]         status,
    output logic [6:0]         range_count,
    output logic [31:0]        member_total
);
    import isb_pkg::*;
    localparam int IW = $clog2(MAX_RANGES + 1) + 1;

    cmd_t          cmd;
    stat_t         stat;
    logic [IW-1:0] set_count;

    isb_control u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ready),
        .stat(stat), .cmd(cmd)
    );

    isb_datapath #(.MAX_RANGES(MAX_RANGES), .IW(IW)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .opcode(opcode), .range_low(range_low), .range_high(range_high),
        .query_value(query_value),
        .member_q(is_member), .status_q(status),
        .set_count(set_count), .set_total(member_total)
    );

    // The port carries the count masked to seven bits.
    assign range_count = 7'(set_count);
endmodule

// ----- src/isb_checker.sv -----
// Port-level checker of the interval set block, bound to the top level.
// Depends on isb_pkg and interval_set_build_and_lookup_assert.svh.
`include "interval_set_build_and_lookup_assert.svh"
module isb_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic       is_member,
    input logic [1:0] status
);
    import isb_pkg::*;

    `ISB_ASSERT_IMP(a_one_side, clk, rst_n, out_valid, !in_ready, "input ready while busy")
    `ISB_ASSERT_NXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(status), "dropped")
    `ISB_ASSERT_IMP(a_member_ok, clk, rst_n, out_valid && is_member, status == ST_DONE, "member")
    `ISB_ASSERT_NXT(a_no_dup, clk, rst_n, out_valid && out_ready, !out_valid, "result repeated")
    `ISB_ASSERT_NXT(a_one_item, clk, rst_n, in_valid && in_ready, !in_ready, "second transfer")
endmodule

bind interval_set_build_and_lookup isb_checker u_isb_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready),
    .is_member(is_member), .status(status)
);
